/* rtl/core/combination_generator_macros.svh */
// Assertion macros for the combination generator.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef COMBINATION_GENERATOR_MACROS_SVH
`define COMBINATION_GENERATOR_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define CG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define CG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cg_pkg.sv */
// Shared types, widths and codes of the combination generator.
// No dependencies; used by every module of the block.
package cg_pkg;

    localparam int ELEM_W      = 64;
    localparam int IDX_W       = 7;
    localparam int CNT_W       = 4;
    localparam int CMD_W       = 2;
    localparam int EIDX_W      = 6;
    localparam int STAT_W      = 2;
    localparam int NUM_MEMBERS = 8;
    localparam int SLOT_W      = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_COMBO     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ACK       = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_CFG_ERR   = 2'd3;

    // Register index codes (byte address bit 2)
    localparam logic REG_SET_SIZE     = 1'b0;
    localparam logic REG_CHOOSE_COUNT = 1'b1;

    typedef logic [ELEM_W-1:0] cg_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] set_size;
        logic [CNT_W-1:0] choose_count;
        logic             restart;
    } cg_cfg_t;

    typedef struct packed {
        logic [NUM_MEMBERS-1:0][ELEM_W-1:0] member;
        logic                               final_combo;
        logic [STAT_W-1:0]                  status;
    } cg_result_t;

endpackage

/* rtl/core/cg_elem_store.sv */
// Element store: one write port, one read port with registered read data.
// Depends on cg_pkg for the word type.
module cg_elem_store #(
    parameter int DEPTH = 64
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  cg_pkg::cg_word_t          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output cg_pkg::cg_word_t          rd_data
);

    cg_pkg::cg_word_t mem [DEPTH];
    cg_pkg::cg_word_t rd_data_reg;

    // Write the loaded word, read one word a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/cg_enum_ctrl.sv */
// Enumeration sequencer: index memory, pivot scan and result assembly.
// Depends on cg_pkg; drives the element store ports.
module cg_enum_ctrl #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_CHOOSE   = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cg_pkg::cg_cfg_t                   cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cg_pkg::CMD_W-1:0]          command,
    input  logic [cg_pkg::EIDX_W-1:0]         elem_index,
    input  cg_pkg::cg_word_t                  elem_value,
    output logic                              st_wr_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]   st_wr_addr,
    output cg_pkg::cg_word_t                  st_wr_data,
    output logic                              st_rd_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]   st_rd_addr,
    input  cg_pkg::cg_word_t                  st_rd_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output cg_pkg::cg_result_t                res
);

    localparam int SAW    = $clog2(MAX_ELEMENTS);
    localparam int CDEPTH = MAX_CHOOSE + 2;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int IW     = cg_pkg::IDX_W;
    localparam int TW     = cg_pkg::CNT_W;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    // Index memory
    logic [IW-1:0]  cmem [CDEPTH];
    logic [IW-1:0]  cm_rdata_reg;
    logic           cm_we;
    logic [CAW-1:0] cm_waddr;
    logic [IW-1:0]  cm_wdata;
    logic           cm_re;
    logic [CAW-1:0] cm_raddr;

    // Control state
    logic [2:0]     state_reg, state_next;
    logic           ack_pend_reg, ack_pend_next;
    logic [CAW-1:0] init_cnt_reg, init_cnt_next;
    logic [TW-1:0]  pivot_reg, pivot_next;
    logic           done_reg, done_next;
    logic [CAW-1:0] rd_cnt_reg, rd_cnt_next;
    logic           rd_act_reg, rd_act_next;
    logic           ci_vld_reg, ci_vld_next;
    logic [CAW-1:0] ci_k_reg, ci_k_next;
    logic           st_vld_reg, st_vld_next;
    logic [cg_pkg::SLOT_W-1:0] st_k_reg, st_k_next;
    logic           ident_reg, ident_next;
    logic           scan_on_reg, scan_on_next;
    logic [IW-1:0]  prev_reg, prev_next;
    logic           tw_en_reg, tw_en_next;
    logic [CAW-1:0] tw_addr_reg, tw_addr_next;
    logic [IW-1:0]  tw_data_reg, tw_data_next;

    // Result under construction
    logic [cg_pkg::NUM_MEMBERS-1:0][cg_pkg::ELEM_W-1:0] wk_member_reg, wk_member_next;
    logic                      wk_final_reg, wk_final_next;
    logic [cg_pkg::STAT_W-1:0] wk_status_reg, wk_status_next;

    // Derived values
    logic [TW-1:0] t_val;
    logic [IW-1:0] n_val;
    logic [TW-1:0] teff;
    logic [TW:0]   t_ext, t_p1, teff_ext, teff_p1;
    logic [TW:0]   ck5, rk5, ik5;
    logic [TW-1:0] piv_sel;
    logic [IW:0]   x_val, c_ext;
    logic          cfg_bad;
    logic          ident;

    assign t_val    = cfg.choose_count;
    assign n_val    = cfg.set_size;
    assign teff     = (32'(t_val) > MAX_CHOOSE) ? TW'(MAX_CHOOSE) : t_val;
    assign t_ext    = {1'b0, t_val};
    assign t_p1     = t_ext + (TW+1)'(1);
    assign teff_ext = {1'b0, teff};
    assign teff_p1  = teff_ext + (TW+1)'(1);
    assign ck5      = (TW+1)'(ci_k_reg);
    assign rk5      = (TW+1)'(rd_cnt_reg);
    assign ik5      = (TW+1)'(init_cnt_reg);
    assign piv_sel  = (pivot_reg > t_val) ? t_val : pivot_reg;
    assign x_val    = {1'b0, prev_reg} + (IW+1)'(1);
    assign c_ext    = {1'b0, cm_rdata_reg};
    assign ident    = ({{(IW-TW){1'b0}}, t_val} == n_val);
    assign cfg_bad  = (t_val == '0) || (32'(t_val) > MAX_CHOOSE)
                   || (32'(n_val) > MAX_ELEMENTS) || ({{(IW-TW){1'b0}}, t_val} > n_val);

    assign s_ready   = (state_reg == S_IDLE) && !cfg.restart;
    assign res_valid = (state_reg == S_RESP);
    assign res.member      = wk_member_reg;
    assign res.final_combo = wk_final_reg;
    assign res.status      = wk_status_reg;

    // Index memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cm_we) begin
            cmem[cm_waddr] <= cm_wdata;
        end
        if (cm_re) begin
            cm_rdata_reg <= cmem[cm_raddr];
        end
    end

    // Sequencer next-state logic
    always_comb begin
        state_next     = state_reg;
        ack_pend_next  = ack_pend_reg;
        init_cnt_next  = init_cnt_reg;
        pivot_next     = pivot_reg;
        done_next      = done_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_act_next    = rd_act_reg;
        ci_vld_next    = 1'b0;
        ci_k_next      = ci_k_reg;
        st_vld_next    = 1'b0;
        st_k_next      = st_k_reg;
        ident_next     = ident_reg;
        scan_on_next   = scan_on_reg;
        prev_next      = prev_reg;
        tw_en_next     = tw_en_reg;
        tw_addr_next   = tw_addr_reg;
        tw_data_next   = tw_data_reg;
        wk_member_next = wk_member_reg;
        wk_final_next  = wk_final_reg;
        wk_status_next = wk_status_reg;
        cm_we          = 1'b0;
        cm_waddr       = '0;
        cm_wdata       = '0;
        cm_re          = 1'b0;
        cm_raddr       = rd_cnt_reg;
        st_wr_en       = 1'b0;
        st_wr_addr     = SAW'(elem_index);
        st_wr_data     = elem_value;
        st_rd_en       = 1'b0;
        st_rd_addr     = '0;

        unique case (state_reg)
            // Rewrite the index vector to the first combination
            S_INIT: begin
                cm_we      = 1'b1;
                cm_waddr   = init_cnt_reg;
                pivot_next = teff;
                done_next  = 1'b0;
                if (ik5 < teff_ext) begin
                    cm_wdata = IW'(init_cnt_reg);
                end else if (ik5 == teff_ext) begin
                    cm_wdata = n_val;
                end else begin
                    cm_wdata = '0;
                end
                if (ik5 == teff_p1) begin
                    state_next    = ack_pend_reg ? S_RESP : S_IDLE;
                    ack_pend_next = 1'b0;
                end else begin
                    init_cnt_next = init_cnt_reg + CAW'(1);
                end
            end

            // Take a command
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    wk_member_next = '0;
                    wk_final_next  = 1'b0;
                    wk_status_next = cg_pkg::ST_ACK;
                    unique case (command)
                        cg_pkg::CMD_LOAD: begin
                            st_wr_en   = (32'(elem_index) < MAX_ELEMENTS);
                            state_next = S_RESP;
                        end
                        cg_pkg::CMD_RESTART: begin
                            state_next    = S_INIT;
                            init_cnt_next = '0;
                            ack_pend_next = 1'b1;
                        end
                        cg_pkg::CMD_NEXT: begin
                            priority if (cfg_bad) begin
                                wk_status_next = cg_pkg::ST_CFG_ERR;
                                state_next     = S_RESP;
                            end else if (done_reg) begin
                                wk_status_next = cg_pkg::ST_EXHAUSTED;
                                state_next     = S_RESP;
                            end else begin
                                wk_status_next = cg_pkg::ST_COMBO;
                                state_next     = S_RUN;
                                rd_cnt_next    = '0;
                                rd_act_next    = 1'b1;
                                ident_next     = ident;
                                tw_en_next     = 1'b0;
                                scan_on_next   = 1'b0;
                                priority if (ident) begin
                                    wk_final_next = 1'b1;
                                    done_next     = 1'b1;
                                end else if (piv_sel != '0) begin
                                    // Pivot still inside: set c[j-1] = j
                                    tw_en_next   = 1'b1;
                                    tw_addr_next = CAW'(piv_sel - TW'(1));
                                    tw_data_next = IW'(piv_sel);
                                    pivot_next   = piv_sel - TW'(1);
                                end else begin
                                    scan_on_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Stream the index vector: fetch members and scan for the pivot
            S_RUN: begin
                if (rd_act_reg) begin
                    cm_re       = 1'b1;
                    ci_vld_next = 1'b1;
                    ci_k_next   = rd_cnt_reg;
                    if (rk5 == t_p1) begin
                        rd_act_next = 1'b0;
                    end else begin
                        rd_cnt_next = rd_cnt_reg + CAW'(1);
                    end
                end
                if (ci_vld_reg) begin
                    if (ck5 < t_ext) begin
                        st_rd_en    = 1'b1;
                        st_rd_addr  = ident_reg ? SAW'(ci_k_reg) : SAW'(cm_rdata_reg);
                        st_vld_next = 1'b1;
                        st_k_next   = cg_pkg::SLOT_W'(ci_k_reg);
                    end
                    if (scan_on_reg) begin
                        priority if (ci_k_reg == '0) begin
                            prev_next = cm_rdata_reg;
                        end else if (ci_k_reg == CAW'(1)) begin
                            if (x_val < c_ext) begin
                                // Bump the lowest index
                                tw_en_next   = 1'b1;
                                tw_addr_next = '0;
                                tw_data_next = IW'(x_val);
                                pivot_next   = '0;
                                scan_on_next = 1'b0;
                            end else begin
                                prev_next = cm_rdata_reg;
                            end
                        end else begin
                            // Reset c[j-2] to its floor, then test c[j-1]+1 against c[j]
                            cm_we    = 1'b1;
                            cm_waddr = ci_k_reg - CAW'(2);
                            cm_wdata = IW'(ci_k_reg - CAW'(2));
                            if ((x_val != c_ext) || (ck5 > t_ext)) begin
                                scan_on_next = 1'b0;
                                if (ck5 > t_ext) begin
                                    pivot_next    = '0;
                                    done_next     = 1'b1;
                                    wk_final_next = 1'b1;
                                end else begin
                                    tw_en_next   = 1'b1;
                                    tw_addr_next = ci_k_reg - CAW'(1);
                                    tw_data_next = IW'(x_val);
                                    pivot_next   = TW'(ci_k_reg - CAW'(1));
                                end
                            end else begin
                                prev_next = cm_rdata_reg;
                            end
                        end
                    end
                end
                if (st_vld_reg) begin
                    wk_member_next[st_k_reg] = st_rd_data;
                end
                if (!rd_act_reg && !ci_vld_reg && !st_vld_reg) begin
                    state_next = S_TAIL;
                end
            end

            // Apply the pending index update
            S_TAIL: begin
                if (tw_en_reg) begin
                    cm_we    = 1'b1;
                    cm_waddr = tw_addr_reg;
                    cm_wdata = tw_data_reg;
                end
                tw_en_next = 1'b0;
                state_next = S_RESP;
            end

            // Hold the result until the output stage takes it
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_INIT;
            end
        endcase

        // A register write restarts the enumeration
        if (cfg.restart) begin
            state_next    = S_INIT;
            init_cnt_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            ack_pend_reg <= 1'b0;
            init_cnt_reg <= '0;
            pivot_reg    <= TW'(1);
            done_reg     <= 1'b0;
            rd_cnt_reg   <= '0;
            rd_act_reg   <= 1'b0;
            ci_vld_reg   <= 1'b0;
            st_vld_reg   <= 1'b0;
            ident_reg    <= 1'b0;
            scan_on_reg  <= 1'b0;
            tw_en_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ack_pend_reg <= ack_pend_next;
            init_cnt_reg <= init_cnt_next;
            pivot_reg    <= pivot_next;
            done_reg     <= done_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_act_reg   <= rd_act_next;
            ci_vld_reg   <= ci_vld_next;
            st_vld_reg   <= st_vld_next;
            ident_reg    <= ident_next;
            scan_on_reg  <= scan_on_next;
            tw_en_reg    <= tw_en_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ci_k_reg      <= ci_k_next;
        st_k_reg      <= st_k_next;
        prev_reg      <= prev_next;
        tw_addr_reg   <= tw_addr_next;
        tw_data_reg   <= tw_data_next;
        wk_member_reg <= wk_member_next;
        wk_final_reg  <= wk_final_next;
        wk_status_reg <= wk_status_next;
    end

endmodule

/* rtl/core/combination_generator.sv */
// Next: t+2 reads of the index memory, t of them feeding one element store read each, then
// pivot scan drain, index update and output stage between transfer and result.
// Load and unknown commands go straight to the output stage. Restart runs an index rewrite.
// One command in flight at a time; a finished result waits in the output register.
// Reset, and any register write, runs an index rewrite sweep with s_ready low; the
// element store is not cleared.
`include "combination_generator_macros.svh"

module combination_generator #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_CHOOSE   = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Command channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cg_pkg::CMD_W-1:0]   s_command,
    input  logic [cg_pkg::EIDX_W-1:0]  s_elem_index,
    input  logic [cg_pkg::ELEM_W-1:0]  s_elem_value,
    // Result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_0,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_1,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_2,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_3,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_4,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_5,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_6,
    output logic [cg_pkg::ELEM_W-1:0]  m_member_7,
    output logic                       m_final_combo,
    output logic [cg_pkg::STAT_W-1:0]  m_status,
    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int SAW = $clog2(MAX_ELEMENTS);

    logic [cg_pkg::IDX_W-1:0] set_size_reg, set_size_next;
    logic [cg_pkg::CNT_W-1:0] choose_count_reg, choose_count_next;
    logic                     cfg_wr;
    cg_pkg::cg_cfg_t          cfg;

    logic                     st_wr_en;
    logic [SAW-1:0]           st_wr_addr;
    cg_pkg::cg_word_t         st_wr_data;
    logic                     st_rd_en;
    logic [SAW-1:0]           st_rd_addr;
    cg_pkg::cg_word_t         st_rd_data;

    logic                     res_valid;
    logic                     res_ready;
    cg_pkg::cg_result_t       res;

    logic                                               m_valid_reg, m_valid_next;
    logic [cg_pkg::NUM_MEMBERS-1:0][cg_pkg::ELEM_W-1:0] m_member_reg;
    logic                                               m_final_reg;
    logic [cg_pkg::STAT_W-1:0]                          m_status_reg;

    // Register port: decode on address bit 2, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        set_size_next     = set_size_reg;
        choose_count_next = choose_count_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                cg_pkg::REG_SET_SIZE:     set_size_next     = pwdata[cg_pkg::IDX_W-1:0];
                cg_pkg::REG_CHOOSE_COUNT: choose_count_next = pwdata[cg_pkg::CNT_W-1:0];
                default:                  set_size_next     = set_size_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg     <= cg_pkg::IDX_W'(1);
            choose_count_reg <= cg_pkg::CNT_W'(1);
        end else begin
            set_size_reg     <= set_size_next;
            choose_count_reg <= choose_count_next;
        end
    end

    assign prdata = (paddr[2] == cg_pkg::REG_CHOOSE_COUNT) ? 32'(choose_count_reg)
                                                           : 32'(set_size_reg);

    assign cfg.set_size     = set_size_reg;
    assign cfg.choose_count = choose_count_reg;
    assign cfg.restart      = cfg_wr;

    cg_elem_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    cg_enum_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_CHOOSE   (MAX_CHOOSE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .command    (s_command),
        .elem_index (s_elem_index),
        .elem_value (s_elem_value),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_rd_en   (st_rd_en),
        .st_rd_addr (st_rd_addr),
        .st_rd_data (st_rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: load a result when the slot is free or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_member_reg <= res.member;
            m_final_reg  <= res.final_combo;
            m_status_reg <= res.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_member_0    = m_member_reg[0];
    assign m_member_1    = m_member_reg[1];
    assign m_member_2    = m_member_reg[2];
    assign m_member_3    = m_member_reg[3];
    assign m_member_4    = m_member_reg[4];
    assign m_member_5    = m_member_reg[5];
    assign m_member_6    = m_member_reg[6];
    assign m_member_7    = m_member_reg[7];
    assign m_final_combo = m_final_reg;
    assign m_status      = m_status_reg;

    // Non-combination results carry no members and no final flag
    `CG_ASSERT_NOW(a_plain_result, res_valid && (res.status != cg_pkg::ST_COMBO), !res.final_combo && (res.member == '0), "non-combination result carries data")
    // A register write blocks commands while the index vector is rewritten
    `CG_ASSERT_NEXT(a_restart_blocks, cfg.restart, !s_ready, "command taken during index rewrite")
    // No command is taken while a result waits for the output stage
    `CG_ASSERT_NOW(a_one_in_flight, res_valid, !s_ready, "command taken while result pending")

endmodule

/* dv/cg_combo_checker.sv */
// Result checker for the combination generator: snoops the command, result and
// register channels, predicts each result and compares it field by field.
// Depends on cg_pkg for widths, command and status codes and the result struct.
module cg_combo_checker #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_CHOOSE   = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [cg_pkg::CMD_W-1:0]   s_command,
    input  logic [cg_pkg::EIDX_W-1:0]  s_elem_index,
    input  logic [cg_pkg::ELEM_W-1:0]  s_elem_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_0,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_1,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_2,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_3,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_4,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_5,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_6,
    input  logic [cg_pkg::ELEM_W-1:0]  m_member_7,
    input  logic                       m_final_combo,
    input  logic [cg_pkg::STAT_W-1:0]  m_status,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output int                         pending_combos,
    output int                         mismatches
);
    import cg_pkg::*;

    // Shadow of the block: element store, index vector, pivot and registers
    logic [ELEM_W-1:0] elem_mem [MAX_ELEMENTS];
    logic [IDX_W-1:0]  idx_vec [MAX_CHOOSE+2];
    logic [CNT_W-1:0]  pivot;
    logic              all_done;
    logic [IDX_W-1:0]  n_reg;
    logic [CNT_W-1:0]  t_reg;

    cg_result_t due_combos [$];
    int         result_no;

    initial begin
        pending_combos = 0;
        mismatches     = 0;
        result_no      = 0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 100)
            $display("ERROR: result %0d %s: want %h got %h", result_no, field, want, got);
    endtask

    // Rewind the index vector to the first combination
    function automatic void rewind_indices();
        int t;
        t = (int'(t_reg) > MAX_CHOOSE) ? MAX_CHOOSE : int'(t_reg);
        for (int k = 0; k < MAX_CHOOSE + 2; k++)
            idx_vec[k] = '0;
        for (int k = 0; k < t; k++)
            idx_vec[k] = IDX_W'(k);
        idx_vec[t]     = n_reg;
        idx_vec[t + 1] = '0;
        pivot          = CNT_W'(t);
        all_done       = 1'b0;
    endfunction

    // Step the index vector; returns 1 when the enumeration has run out
    function automatic bit step_indices(input int t);
        int j;
        int x;
        j = int'(pivot);
        if (j > t)
            j = t;
        if (j > 0) begin
            idx_vec[j - 1] = IDX_W'(j);
            pivot          = CNT_W'(j - 1);
            return 1'b0;
        end
        if (int'(idx_vec[0]) + 1 < int'(idx_vec[1])) begin
            idx_vec[0] = idx_vec[0] + 1'b1;
            pivot      = '0;
            return 1'b0;
        end
        j = 2;
        while (1) begin
            idx_vec[j - 2] = IDX_W'(j - 2);
            x = int'(idx_vec[j - 1]) + 1;
            if (x != int'(idx_vec[j]) || j > t)
                break;
            j++;
        end
        if (j > t) begin
            pivot = '0;
            return 1'b1;
        end
        idx_vec[j - 1] = IDX_W'(x);
        pivot          = CNT_W'(j - 1);
        return 1'b0;
    endfunction

    // Work out the result of one command and update the shadow state
    function automatic cg_result_t combo_for_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [EIDX_W-1:0] idx,
                                                     input logic [ELEM_W-1:0] val);
        cg_result_t r;
        int t;
        int n;
        r        = '0;
        r.status = ST_ACK;
        t        = int'(t_reg);
        n        = int'(n_reg);
        case (cmd)
            CMD_LOAD: begin
                elem_mem[idx] = val;
            end
            CMD_RESTART: begin
                rewind_indices();
            end
            CMD_NEXT: begin
                if (t == 0 || t > MAX_CHOOSE || n > MAX_ELEMENTS || t > n) begin
                    r.status = ST_CFG_ERR;
                end else if (all_done) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    r.status = ST_COMBO;
                    if (t == n) begin
                        for (int k = 0; k < t; k++)
                            r.member[k] = elem_mem[k];
                        r.final_combo = 1'b1;
                        all_done      = 1'b1;
                    end else begin
                        for (int k = 0; k < t; k++)
                            r.member[k] = elem_mem[idx_vec[k]];
                        if (step_indices(t)) begin
                            r.final_combo = 1'b1;
                            all_done      = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Watch register writes, command and result transfers at each edge
    always @(posedge aclk) begin : watch
        cg_result_t want;
        cg_result_t got;
        if (!aresetn) begin
            for (int k = 0; k < MAX_ELEMENTS; k++)
                elem_mem[k] = '0;
            n_reg = IDX_W'(1);
            t_reg = CNT_W'(1);
            rewind_indices();
            due_combos.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SET_SIZE)
                    n_reg = pwdata[IDX_W-1:0];
                else
                    t_reg = pwdata[CNT_W-1:0];
                rewind_indices();
            end
            if (m_valid && m_ready) begin
                got.member[0]  = m_member_0;
                got.member[1]  = m_member_1;
                got.member[2]  = m_member_2;
                got.member[3]  = m_member_3;
                got.member[4]  = m_member_4;
                got.member[5]  = m_member_5;
                got.member[6]  = m_member_6;
                got.member[7]  = m_member_7;
                got.final_combo = m_final_combo;
                got.status      = m_status;
                if (due_combos.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want = due_combos.pop_front();
                    for (int k = 0; k < NUM_MEMBERS; k++)
                        if (got.member[k] !== want.member[k])
                            report_mismatch($sformatf("member_%0d", k),
                                            want.member[k], got.member[k]);
                    if (got.final_combo !== want.final_combo)
                        report_mismatch("final_combo", want.final_combo, got.final_combo);
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                end
                result_no++;
            end
            if (s_valid && s_ready)
                due_combos.insert(due_combos.size(),
                                  combo_for_command(s_command, s_elem_index, s_elem_value));
        end
        pending_combos <= due_combos.size();
    end

endmodule

/* dv/tb_combination_generator.sv */
// Top of the combination generator testbench: clock, reset, command and register
// stimulus, result-side back-pressure and the final verdict.
// Depends on cg_pkg, the combination_generator RTL and cg_combo_checker.
module tb_combination_generator;
    import cg_pkg::*;

    localparam int                ITEMS         = 1700;
    localparam int                SETTLE_CYCLES = 16;
    localparam int                LONG_HOLD     = 300;
    localparam logic [CMD_W-1:0]  CMD_NOP       = 2'd3;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command    = CMD_LOAD;
    logic [EIDX_W-1:0]   s_elem_index = '0;
    logic [ELEM_W-1:0]   s_elem_value = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [ELEM_W-1:0]   m_member_0, m_member_1, m_member_2, m_member_3;
    logic [ELEM_W-1:0]   m_member_4, m_member_5, m_member_6, m_member_7;
    logic                m_final_combo;
    logic [STAT_W-1:0]   m_status;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [2:0]          paddr        = '0;
    logic [31:0]         pwdata       = '0;
    logic [31:0]         prdata;
    logic                pready;

    int pending_combos;
    int mismatches;
    int sent_total = 0;
    int item_count = 0;
    int tx_calm    = 0;
    bit loaded [64];

    always #4 aclk = ~aclk;

    combination_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_elem_index(s_elem_index), .s_elem_value(s_elem_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_member_0(m_member_0), .m_member_1(m_member_1),
        .m_member_2(m_member_2), .m_member_3(m_member_3),
        .m_member_4(m_member_4), .m_member_5(m_member_5),
        .m_member_6(m_member_6), .m_member_7(m_member_7),
        .m_final_combo(m_final_combo), .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cg_combo_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_elem_index(s_elem_index), .s_elem_value(s_elem_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_member_0(m_member_0), .m_member_1(m_member_1),
        .m_member_2(m_member_2), .m_member_3(m_member_3),
        .m_member_4(m_member_4), .m_member_5(m_member_5),
        .m_member_6(m_member_6), .m_member_7(m_member_7),
        .m_final_combo(m_final_combo), .m_status(m_status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .pending_combos(pending_combos), .mismatches(mismatches)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint n_choose_k(input int n, input int k);
        longint r;
        r = 1;
        for (int i = 0; i < k; i++)
            r = r * (n - i) / (i + 1);
        return r;
    endfunction

    // Offer one command and hold it until the transfer
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [EIDX_W-1:0] idx,
                            input logic [ELEM_W-1:0] val);
        int gap;
        if (tx_calm > 0) begin
            gap = 0;
            tx_calm--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0)
                tx_calm = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_elem_index <= idx;
        s_elem_value <= val;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_LOAD)
            loaded[idx] = 1'b1;
        if (cmd != CMD_NOP)
            item_count++;
        sent_total++;
    endtask

    task automatic send_next();
        send_cmd(CMD_NEXT, EIDX_W'($urandom), {$urandom, $urandom});
    endtask

    // Drop valid and hold off until every result is back
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_combos != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Write both registers, with random junk above the used bits half the time
    task automatic set_config(input int n, input int t);
        logic [31:0] junk;
        logic [6:0]  n_bits;
        logic [3:0]  t_bits;
        n_bits = n[6:0];
        t_bits = t[3:0];
        junk   = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_SET_SIZE, {junk[31:7], n_bits});
        junk   = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_CHOOSE_COUNT, {junk[31:4], t_bits});
    endtask

    // Load every store entry the enumeration can read that is still unwritten
    task automatic fill_store(input int n);
        for (int i = 0; i < n && i < 64; i++)
            if (!loaded[i])
                send_cmd(CMD_LOAD, EIDX_W'(i), {$urandom, $urandom});
    endtask

    // Result side: random back-pressure, calm stretches and one long hold
    // placed inside the first long run of next commands
    initial begin : result_sink
        int  idle_left;
        int  calm_left;
        int  hold_left;
        bit  held;
        idle_left = 0;
        calm_left = 0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && sent_total >= 100) begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    idle_left = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        calm_left = $urandom_range(30, 150);
                end
            end
        end
    end

    // Stimulus: directed opening, then random phases of one setting each
    initial begin : stimulus
        int n;
        int t;
        int cmds;
        int cls;
        int r;
        int phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        // Extreme words and the top store position
        send_cmd(CMD_LOAD, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_LOAD, 6'd1, 64'h0);
        send_cmd(CMD_LOAD, 6'd2, 64'h5555_5555_5555_5555);
        send_cmd(CMD_LOAD, 6'd3, 64'hAAAA_AAAA_AAAA_AAAA);
        send_cmd(CMD_LOAD, 6'd4, 64'hFFFF_FFFF_0000_0000);
        send_cmd(CMD_LOAD, 6'd5, 64'h0000_0000_FFFF_FFFF);
        send_cmd(CMD_LOAD, 6'd6, {$urandom, $urandom});
        send_cmd(CMD_LOAD, 6'd7, {$urandom, $urandom});
        send_cmd(CMD_LOAD, 6'd63, {$urandom, $urandom});

        // Reset setting: single combination, exhaustion, unknown command, restart
        send_next();
        send_next();
        send_cmd(CMD_NOP, 6'd0, 64'h0);
        send_cmd(CMD_RESTART, 6'd0, 64'h0);
        send_next();
        wait_idle();

        // Choose all of eight, then the smallest real enumeration
        set_config(8, 8);
        send_next();
        send_next();
        wait_idle();
        set_config(2, 1);
        send_next();
        send_next();
        send_next();
        wait_idle();

        // Bad settings: t above n, t above the limit, t of zero, n of zero
        set_config(3, 4);
        send_next();
        wait_idle();
        set_config(64, 15);
        send_next();
        wait_idle();
        set_config(127, 0);
        send_next();
        wait_idle();
        set_config(0, 1);
        send_next();
        wait_idle();

        phase = 0;
        while (item_count < ITEMS) begin
            cls = $urandom_range(0, 99);
            if (phase == 0) begin
                n    = 64;
                t    = 8;
                cmds = 40;
            end else if (cls < 65) begin
                n    = $urandom_range(1, 10);
                t    = $urandom_range(1, (n < 8) ? n : 8);
                cmds = int'(n_choose_k(n, t)) + $urandom_range(0, 3);
            end else if (cls < 80) begin
                n    = $urandom_range(11, 64);
                t    = $urandom_range(1, 8);
                cmds = $urandom_range(10, 50);
            end else if (cls < 90) begin
                t    = $urandom_range(1, 8);
                n    = t;
                cmds = $urandom_range(1, 4);
            end else begin
                do begin
                    n = $urandom_range(0, 127);
                    t = $urandom_range(0, 15);
                end while (!(t == 0 || t > 8 || n > 64 || t > n));
                cmds = $urandom_range(3, 8);
            end
            set_config(n, t);
            if (t >= 1 && t <= 8 && n <= 64 && t <= n)
                fill_store(n);

            // Mostly next, with stray loads, restarts and unknown commands
            for (int i = 0; i < cmds; i++) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_next();
                else if (r < 92)
                    send_cmd(CMD_LOAD, EIDX_W'($urandom_range(0, 63)), {$urandom, $urandom});
                else if (r < 97)
                    send_cmd(CMD_RESTART, EIDX_W'($urandom), {$urandom, $urandom});
                else
                    send_cmd(CMD_NOP, EIDX_W'($urandom), {$urandom, $urandom});
            end
            wait_idle();
            phase++;
        end

        if (mismatches == 0)
            $display("combination_generator: match");
        else
            $display("combination_generator: mismatch");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("combination_generator: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cg_pkg.sv
rtl/core/cg_elem_store.sv
rtl/core/cg_enum_ctrl.sv
rtl/core/combination_generator.sv
dv/cg_combo_checker.sv
dv/tb_combination_generator.sv
